// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = 11;
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(COLS);
  localparam logic [COL_W-1:0]  TAB_STEP   = COL_W'(4);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] ADDR_COLS  = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] ADDR_CELLS = ADDR_W'(CELLS);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLS);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_CLEAR,
    OP_COPY,
    OP_FILL,
    OP_NEWLINE,
    OP_TAB,
    OP_WRITE,
    OP_READ
  } tcw_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_COPY,
    ST_FILL,
    ST_WRITE,
    ST_CLEAR,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              is_newline;
    logic              is_tab;
    logic              row_last;
    logic              col_past;
    logic              sweep_last;
    logic              copy_last;
  } tcw_status_t;

endpackage

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// Sequencer for the text console writer: decodes requests and runs memory sweeps.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire tcw_status_t status,
  output tcw_op_t          op,
  output logic             busy,
  output logic             done
);

  tcw_state_t state;
  tcw_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (status.mode == MODE_PUT) begin
          priority if (status.is_newline) begin
            state_next = status.row_last ? ST_COPY : ST_DONE;
          end else if (status.is_tab) begin
            state_next = ST_DONE;
          end else if (status.col_past) begin
            state_next = status.row_last ? ST_COPY : ST_WRITE;
          end else begin
            state_next = ST_DONE;
          end
        end else if (status.mode == MODE_CLEAR) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_COPY: begin
        if (status.copy_last) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (status.sweep_last) begin
          state_next = (status.is_newline) ? ST_DONE : ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_CLEAR: begin
        if (status.sweep_last) state_next = ST_DONE;
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op   = OP_NONE;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_INIT: op = OP_INIT;
      ST_IDLE: begin
        busy = 1'b0;
        if (start) op = OP_LOAD;
      end
      ST_DECODE: begin
        priority if (status.mode == MODE_PUT) begin
          priority if (status.is_newline) begin
            op = status.row_last ? OP_NONE : OP_NEWLINE;
          end else if (status.is_tab) begin
            op = OP_TAB;
          end else if (status.col_past) begin
            op = status.row_last ? OP_NONE : OP_NEWLINE;
          end else begin
            op = OP_WRITE;
          end
        end else if (status.mode == MODE_READ) begin
          op = OP_READ;
        end else begin
          op = OP_NONE;
        end
      end
      ST_COPY:  op = OP_COPY;
      ST_FILL:  op = OP_FILL;
      ST_WRITE: op = OP_WRITE;
      ST_CLEAR: op = OP_CLEAR;
      ST_DONE:  done = 1'b1;
      default:  op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tcw_datapath.sv =====
// Cell store, cursor, sweep pointer and attribute register of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcw_op_t           op,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [ADDR_W-1:0] cell_index,
  input  wire logic              attr_we,
  input  wire logic [ATTR_W-1:0] attr_data,
  output tcw_status_t            status,
  output logic [ROW_W-1:0]       cursor_row,
  output logic [COL_W-1:0]       cursor_col,
  output logic [CHAR_W-1:0]      cell_char,
  output logic [ATTR_W-1:0]      cell_attr,
  output logic                   scrolled
);

  logic [CELL_W-1:0] mem [0:CELLS-1];
  logic [CELL_W-1:0] rd_q;

  logic [ATTR_W-1:0] text_attr;
  logic [MODE_W-1:0] mode_q;
  logic [CHAR_W-1:0] char_q;
  logic [ADDR_W-1:0] index_q;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] ptr;
  logic              scr;
  logic              rd_ok;

  logic              index_ok;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cursor_addr;

  assign index_ok    = (index_q < ADDR_CELLS);
  assign cursor_addr = ADDR_W'(32'(row) * COLS + 32'(col));

  assign status.mode       = mode_q;
  assign status.is_newline = (char_q == CH_NEWLINE);
  assign status.is_tab     = (char_q == CH_TAB);
  assign status.row_last   = (row == ROW_LAST);
  assign status.col_past   = (col >= COL_LIMIT);
  assign status.sweep_last = (ptr == ADDR_LAST);
  assign status.copy_last  = (ptr == COPY_END);

  always_comb begin
    we      = 1'b0;
    wr_addr = ptr;
    wr_data = {text_attr, CH_SPACE};
    rd_addr = '0;
    unique case (op)
      OP_INIT: begin
        we      = 1'b1;
        wr_data = {ATTR_RESET, CH_SPACE};
      end
      OP_CLEAR, OP_FILL: we = 1'b1;
      OP_COPY: begin
        we      = (ptr != '0);
        wr_addr = ptr - 1'b1;
        wr_data = rd_q;
        if (ptr < COPY_END) rd_addr = ptr + ADDR_COLS;
      end
      OP_WRITE: begin
        we      = 1'b1;
        wr_addr = cursor_addr;
        wr_data = {text_attr, char_q};
      end
      OP_READ: begin
        if (index_ok) rd_addr = index_q;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_RESET;
    end else if (attr_we) begin
      text_attr <= attr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      mode_q  <= mode;
      char_q  <= char_code;
      index_q <= cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row   <= '0;
      col   <= '0;
      ptr   <= '0;
      scr   <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      unique case (op)
        OP_LOAD: begin
          ptr   <= '0;
          scr   <= 1'b0;
          rd_ok <= 1'b0;
        end
        OP_INIT, OP_CLEAR: ptr <= ptr + 1'b1;
        OP_COPY: begin
          if (ptr != COPY_END) ptr <= ptr + 1'b1;
        end
        OP_FILL: begin
          ptr <= ptr + 1'b1;
          col <= '0;
          scr <= 1'b1;
        end
        OP_NEWLINE: begin
          col <= '0;
          row <= row + 1'b1;
        end
        OP_TAB: begin
          if (col < COL_LIMIT) col <= col + TAB_STEP;
        end
        OP_WRITE: col <= col + 1'b1;
        OP_READ:  rd_ok <= index_ok;
        default:  ptr <= ptr;
      endcase
    end
  end

  assign cursor_row = row;
  assign cursor_col = col;
  assign cell_char  = rd_ok ? rd_q[CHAR_W-1:0] : '0;
  assign cell_attr  = rd_ok ? rd_q[CELL_W-1:CHAR_W] : '0;
  assign scrolled   = scr;

endmodule

`default_nettype wire

// ===== sv/text_console_writer_unit.sv =====
// Top level of the text console writer: sequencer plus cell store datapath.
`timescale 1ns / 1ps
`default_nettype none

// An 80 by 25 character-cell console. A request is taken when start is high
// and busy is low; its result appears for exactly one cycle with done high
// and cannot be held off. After reset the cell store is cleared to spaces in
// attribute 0x0F, one cell a cycle, with busy high. A printable byte that
// wraps first moves the cursor to the next row and is then written. A scroll
// walks the store through its single write port, one cell a cycle, copying
// each row up and then filling the last row with spaces; a clear sweeps
// every cell. Writes to the attribute register are always taken and are used
// by every space fill and character write that follows, so they belong
// between requests.
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [ADDR_W-1:0] cell_index,
  output logic                   done,
  output logic [ROW_W-1:0]       cursor_row,
  output logic [COL_W-1:0]       cursor_col,
  output logic [CHAR_W-1:0]      cell_char,
  output logic [ATTR_W-1:0]      cell_attr,
  output logic                   scrolled,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [ATTR_W-1:0] cfg_data
);

  tcw_op_t     op;
  tcw_status_t status;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy),
    .done   (done)
  );

  tcw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .mode       (mode),
    .char_code  (char_code),
    .cell_index (cell_index),
    .attr_we    (cfg_valid & cfg_ready),
    .attr_data  (cfg_data),
    .status     (status),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .scrolled   (scrolled)
  );

endmodule

`default_nettype wire

// ===== sim/tb_text_console_writer_unit.sv =====
// Self-checking testbench for the text console writer: directed table, then random sequences.
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
  import tcw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int PLAN_LEN = 17;
  localparam int PHASES = 4;
  localparam int PHASE_ITEMS = 258;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic              scr;
  } console_reply_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] idx;
    logic              typed;
    console_reply_t    reply;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_index;
  logic              done;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic              scrolled;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data;

  text_console_writer_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .char_code  (char_code),
    .cell_index (cell_index),
    .done       (done),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .scrolled   (scrolled),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Mirror of the console state
  logic [CELL_W-1:0] screen_mirror [CELLS];
  logic [ROW_W-1:0]  row_m;
  logic [COL_W-1:0]  col_m;
  logic [ATTR_W-1:0] attr_m;

  console_reply_t awaited_replies [$];
  console_reply_t front_reply;
  plan_row_t      plan [PLAN_LEN];
  int             faults;
  int             items_sent;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #25_000_000;
    $display("tb_text_console_writer_unit: FAIL");
    $finish;
  end

  function automatic void reset_mirror();
    for (int i = 0; i < CELLS; i++) screen_mirror[i] = {ATTR_RESET, CH_SPACE};
    row_m  = '0;
    col_m  = '0;
    attr_m = ATTR_RESET;
  endfunction

  // Returns 1 when the screen scrolls.
  function automatic logic line_feed();
    col_m = '0;
    if (row_m < ROW_LAST) begin
      row_m = row_m + 1'b1;
      return 1'b0;
    end
    for (int i = COLS; i < CELLS; i++) screen_mirror[i - COLS] = screen_mirror[i];
    for (int i = CELLS - COLS; i < CELLS; i++) screen_mirror[i] = {attr_m, CH_SPACE};
    return 1'b1;
  endfunction

  function automatic console_reply_t apply_request(logic [MODE_W-1:0] m,
                                                   logic [CHAR_W-1:0] ch,
                                                   logic [ADDR_W-1:0] idx);
    console_reply_t r;
    r = '0;
    case (m)
      MODE_PUT: begin
        if (ch == CH_NEWLINE) begin
          r.scr = line_feed();
        end else if (ch == CH_TAB) begin
          if (col_m < COL_LIMIT) col_m = col_m + TAB_STEP;
        end else begin
          if (col_m >= COL_LIMIT) r.scr = line_feed();
          screen_mirror[int'(row_m) * COLS + int'(col_m)] = {attr_m, ch};
          col_m = col_m + 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mirror[i] = {attr_m, CH_SPACE};
      end
      MODE_READ: begin
        if (idx < ADDR_CELLS) {r.attr, r.ch} = screen_mirror[idx];
      end
      default: ;
    endcase
    r.row = row_m;
    r.col = col_m;
    return r;
  endfunction

  task automatic issue(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] ch,
                       input logic [ADDR_W-1:0] idx, input bit idling,
                       input bit typed, input console_reply_t typed_reply);
    console_reply_t predicted;
    if (idling && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 8)) @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start      <= 1'b1;
    mode       <= m;
    char_code  <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_request(m, ch, idx);
    awaited_replies.push_back(typed ? typed_reply : predicted);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    attr_m = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] printable_byte();
    logic [CHAR_W-1:0] ch;
    do ch = CHAR_W'($urandom_range(255));
    while (ch == CH_NEWLINE || ch == CH_TAB);
    return ch;
  endfunction

  // One random sequence: text run, tab run, newline run, reads, a stray request or a clear.
  task automatic emit_sequence(input bit idling);
    int                kind;
    int                n;
    logic [ADDR_W-1:0] idx;
    kind = $urandom_range(99);
    if (kind < 40) begin
      n = $urandom_range(1, 40);
      repeat (n) issue(MODE_PUT, printable_byte(), ADDR_W'($urandom), idling, 1'b0, '0);
    end else if (kind < 55) begin
      n = $urandom_range(1, 24);
      repeat (n) issue(MODE_PUT, CH_TAB, ADDR_W'($urandom), idling, 1'b0, '0);
      issue(MODE_PUT, printable_byte(), ADDR_W'($urandom), idling, 1'b0, '0);
    end else if (kind < 68) begin
      n = $urandom_range(1, 5);
      repeat (n) issue(MODE_PUT, CH_NEWLINE, ADDR_W'($urandom), idling, 1'b0, '0);
    end else if (kind < 92) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(7))
          0: idx = ADDR_W'($urandom_range(CELLS, 2047));
          1, 2, 3: idx = ADDR_W'(int'(row_m) * COLS + $urandom_range(0, COLS - 1));
          default: idx = ADDR_W'($urandom_range(0, CELLS - 1));
        endcase
        issue(MODE_READ, CHAR_W'($urandom), idx, idling, 1'b0, '0);
      end
    end else if (kind < 96) begin
      issue(MODE_SPARE, CHAR_W'($urandom), ADDR_W'($urandom), idling, 1'b0, '0);
    end else begin
      issue(MODE_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom), idling, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s expected %0d got %0d", $time, what, want_v, got_v);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t ns: reply with no request pending, row %0d col %0d",
                 $time, cursor_row, cursor_col);
        faults++;
      end else begin
        front_reply = awaited_replies.pop_front();
        check_field("cursor_row", front_reply.row, cursor_row);
        check_field("cursor_col", front_reply.col, cursor_col);
        check_field("cell_char", front_reply.ch, cell_char);
        check_field("cell_attr", front_reply.attr, cell_attr);
        check_field("scrolled", front_reply.scr, scrolled);
      end
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr [PHASES];
    int                phase_end;
    faults     = 0;
    items_sent = 0;
    rst        = 1'b1;
    start      = 1'b0;
    mode       = MODE_PUT;
    char_code  = '0;
    cell_index = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    reset_mirror();

    plan = '{
      '{MODE_READ,  8'd0,       11'd0,      1'b1, '{5'd0, 7'd0, CH_SPACE, ATTR_RESET, 1'b0}},
      '{MODE_READ,  8'd0,       ADDR_LAST,  1'b1, '{5'd0, 7'd0, CH_SPACE, ATTR_RESET, 1'b0}},
      '{MODE_READ,  8'd0,       ADDR_CELLS, 1'b1, '{5'd0, 7'd0, 8'd0, 8'd0, 1'b0}},
      '{MODE_READ,  8'd0,       11'h7FF,    1'b1, '{5'd0, 7'd0, 8'd0, 8'd0, 1'b0}},
      '{MODE_PUT,   8'd65,      11'd0,      1'b1, '{5'd0, 7'd1, 8'd0, 8'd0, 1'b0}},
      '{MODE_PUT,   8'h00,      11'h7FF,    1'b0, '0},
      '{MODE_PUT,   8'hFF,      11'd0,      1'b0, '0},
      '{MODE_READ,  8'd0,       11'd1,      1'b0, '0},
      '{MODE_READ,  8'd0,       11'd2,      1'b0, '0},
      '{MODE_PUT,   CH_TAB,     11'd0,      1'b0, '0},
      '{MODE_PUT,   8'h7E,      11'd0,      1'b0, '0},
      '{MODE_PUT,   CH_NEWLINE, 11'd0,      1'b1, '{5'd1, 7'd0, 8'd0, 8'd0, 1'b0}},
      '{MODE_SPARE, 8'hFF,      11'h7FF,    1'b0, '0},
      '{MODE_READ,  8'd0,       11'd7,      1'b0, '0},
      '{MODE_CLEAR, 8'd0,       11'd0,      1'b0, '0},
      '{MODE_READ,  8'd0,       11'd0,      1'b0, '0},
      '{MODE_READ,  8'd0,       ADDR_LAST,  1'b0, '0}
    };
    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = ATTR_W'($urandom);
    phase_attr[3] = ATTR_W'($urandom);

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++)
      issue(plan[i].mode, plan[i].ch, plan[i].idx, 1'b1, plan[i].typed, plan[i].reply);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_attr(phase_attr[p]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) emit_sequence(p != PHASES - 1);
    end

    drain();
    repeat (20) @(posedge clk);
    if (faults == 0)
      $display("tb_text_console_writer_unit: PASS");
    else
      $display("tb_text_console_writer_unit: FAIL");
    $finish;
  end

endmodule
